[rtl/bpfd_pkg.sv]
// ----------------------------------------------------------------------------
// bpfd_pkg
// Shared types and constants of the bounded packet FIFO with duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfd_pkg;

   localparam int OP_W    = 2;
   localparam int NODE_W  = 16;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 7;
   localparam int LIMIT_W = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // request opcodes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
   localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

   // one stored packet
   typedef struct packed {
      logic [NODE_W-1:0]  src;
      logic [NODE_W-1:0]  dst;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/bpfd_if.sv]
// ----------------------------------------------------------------------------
// bpfd_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfd_req_if;
   import bpfd_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [NODE_W-1:0]   src_node;
   logic [NODE_W-1:0]   dst_node;
   logic [STAMP_W-1:0]  pkt_time;
   logic [STAMP_W-1:0]  range_start;
   logic [STAMP_W-1:0]  range_end;

   modport source (
      output valid, opcode, src_node, dst_node, pkt_time, range_start, range_end,
      input  ready
   );
   modport sink (
      input  valid, opcode, src_node, dst_node, pkt_time, range_start, range_end,
      output ready
   );
endinterface

interface bpfd_rsp_if;
   import bpfd_pkg::*;

   logic                valid;
   logic                ready;
   logic                success;
   logic [NODE_W-1:0]   out_src;
   logic [NODE_W-1:0]   out_dst;
   logic [STAMP_W-1:0]  out_time;
   logic [CNT_W-1:0]    match_count;

   modport source (
      output valid, success, out_src, out_dst, out_time, match_count,
      input  ready
   );
   modport sink (
      input  valid, success, out_src, out_dst, out_time, match_count,
      output ready
   );
endinterface

`default_nettype wire

[rtl/bpfd_ram.sv]
// ----------------------------------------------------------------------------
// bpfd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/bounded_packet_fifo_with_dedup.sv]
// ----------------------------------------------------------------------------
// bounded_packet_fifo_with_dedup
// Circular packet buffer in one RAM with duplicate filter, eviction at a
// programmable limit, pop of the oldest packet and a range count by scan.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          word
//  --------  ----  -----------------  --------------------------------------
//  req_bus   in    valid/ready        opcode, src/dst node, time, range
//  rsp_bus   out   valid/ready        success, forwarded packet, match count
//  csr_*     in    write enable only  memory_limit (7 bits)
//
//  Add and count scan every stored packet, forward reads only the oldest;
//  on an empty buffer, and for an unused opcode, no slot is read. The
//  block is ready for the next word in the cycle after the response
//  register loads. The scan is bound by the single RAM read port: it
//  reads one stored packet per cycle.
//  Reset clears pointers, occupancy and the response valid; the limit returns
//  to 64. The RAM needs no clearing, only live slots are ever read.
//  A new request is taken while a finished response still waits in the
//  output register; a stalled response holds the block in its commit state.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_packet_fifo_with_dedup #(
   parameter int DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bpfd_req_if.sink                           req_bus,
   bpfd_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [bpfd_pkg::LIMIT_W-1:0]  csr_wr_data
);

   import bpfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int LIM_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
   localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(DEPTH);

   // advance a slot pointer with wrap at DEPTH
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   state_type           state_ff, state_in;

   // captured request
   logic [OP_W-1:0]     op_ff, op_in;
   slot_type            key_ff, key_in;
   logic [STAMP_W-1:0]  lo_ff, lo_in;
   logic [STAMP_W-1:0]  hi_ff, hi_in;

   // scan control
   logic [OCC_W-1:0]    scan_len_ff, scan_len_in;
   logic [OCC_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                hit_ff, hit_in;
   logic [CNT_W-1:0]    match_ff, match_in;
   slot_type            hold_ff, hold_in;

   // queue state
   logic [PTR_W-1:0]    oldest_ff, oldest_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_success_ff, rsp_success_in;
   slot_type            rsp_pkt_ff, rsp_pkt_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // ------------------------------------------------------------------------
   // RAM
   // ------------------------------------------------------------------------
   logic                ram_wr_en;
   logic                ram_rd_en;
   slot_type            ram_rd_data;

   bpfd_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // handshake and common terms
   // ------------------------------------------------------------------------
   logic req_fire;
   logic scan_end;
   logic commit;
   logic slot_free;

   // a scan is over once every read is issued and the last data consumed
   assign scan_end  = (issue_cnt_ff == scan_len_ff) && !rd_vld_ff;
   // the response register is free now or is being emptied this cycle
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign commit    = (state_ff == ST_DONE) && slot_free;
   assign req_fire  = req_bus.valid && req_bus.ready;

   // effective limit: zero acts as one, anything above DEPTH acts as DEPTH
   logic [LIM_W-1:0] lim_wide;
   logic [OCC_W-1:0] lim_eff;
   logic [OCC_W-1:0] keep_cnt;
   logic [PTR_W:0]   evict_base;

   always_comb begin
      lim_wide = LIM_W'(limit_ff);
      if (lim_wide == '0) begin
         lim_wide = LIM_W'(1);
      end
      if (lim_wide > DEPTH_LIM) begin
         lim_wide = DEPTH_LIM;
      end
      lim_eff  = lim_wide[OCC_W-1:0];
      keep_cnt = lim_eff - 1'b1;
      // oldest after eviction sits keep_cnt slots behind the tail
      evict_base = (PTR_W + 1)'(tail_ff) - (PTR_W + 1)'(keep_cnt);
      if ((PTR_W + 1)'(tail_ff) < (PTR_W + 1)'(keep_cnt)) begin
         evict_base = evict_base + DEPTH_EXT;
      end
   end

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // state outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_bus.ready = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_SCAN: ram_rd_en = (issue_cnt_ff != scan_len_ff);
         ST_DONE: ram_wr_en = slot_free && (op_ff == OP_ADD) && !hit_ff;
         default: req_bus.ready = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------------
   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      scan_len_in    = scan_len_ff;
      issue_cnt_in   = issue_cnt_ff;
      rd_ptr_in      = rd_ptr_ff;
      rd_vld_in      = ram_rd_en;
      hit_in         = hit_ff;
      match_in       = match_ff;
      hold_in        = hold_ff;
      oldest_in      = oldest_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      limit_in       = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_success_in = rsp_success_ff;
      rsp_pkt_in     = rsp_pkt_ff;
      rsp_count_in   = rsp_count_ff;

      // capture the request and set up the scan from the oldest slot
      if (req_fire) begin
         op_in        = req_bus.opcode;
         key_in.src   = req_bus.src_node;
         key_in.dst   = req_bus.dst_node;
         key_in.stamp = req_bus.pkt_time;
         lo_in        = req_bus.range_start;
         hi_in        = req_bus.range_end;
         issue_cnt_in = '0;
         rd_ptr_in    = oldest_ff;
         hit_in       = 1'b0;
         match_in     = '0;
         unique case (req_bus.opcode)
            OP_ADD, OP_COUNT: scan_len_in = occ_ff;
            OP_FWD:           scan_len_in = (occ_ff != '0) ? OCC_W'(1) : '0;
            default:          scan_len_in = '0;
         endcase
      end

      // issue one read a cycle, walking from the oldest slot
      if (ram_rd_en) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
         rd_ptr_in    = ptr_inc(rd_ptr_ff);
      end

      // compare the slot read last cycle
      if (rd_vld_ff) begin
         hold_in = ram_rd_data;
         if (ram_rd_data == key_ff) begin
            hit_in = 1'b1;
         end
         if ((ram_rd_data.dst == key_ff.dst) && (ram_rd_data.stamp >= lo_ff) &&
             (ram_rd_data.stamp <= hi_ff)) begin
            match_in = match_ff + 1'b1;
         end
      end

      // update the queue and load the response register
      if (commit) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = 1'b0;
         rsp_pkt_in     = '0;
         rsp_count_in   = '0;
         unique case (op_ff)
            OP_ADD: begin
               if (!hit_ff) begin
                  rsp_success_in = 1'b1;
                  tail_in        = ptr_inc(tail_ff);
                  if (occ_ff >= lim_eff) begin
                     // drop the oldest until one below the limit, then append
                     oldest_in = evict_base[PTR_W-1:0];
                     occ_in    = lim_eff;
                  end else begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
            end
            OP_FWD: begin
               if (occ_ff != '0) begin
                  rsp_success_in = 1'b1;
                  rsp_pkt_in     = hold_ff;
                  oldest_in      = ptr_inc(oldest_ff);
                  occ_in         = occ_ff - 1'b1;
               end
            end
            OP_COUNT: rsp_count_in = match_ff;
            default:  rsp_success_in = 1'b0;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // register update
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         oldest_ff    <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         oldest_ff    <= oldest_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      scan_len_ff    <= scan_len_in;
      issue_cnt_ff   <= issue_cnt_in;
      rd_ptr_ff      <= rd_ptr_in;
      hit_ff         <= hit_in;
      match_ff       <= match_in;
      hold_ff        <= hold_in;
      rsp_success_ff <= rsp_success_in;
      rsp_pkt_ff     <= rsp_pkt_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // ------------------------------------------------------------------------
   // response channel
   // ------------------------------------------------------------------------
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.success     = rsp_success_ff;
   assign rsp_bus.out_src     = rsp_pkt_ff.src;
   assign rsp_bus.out_dst     = rsp_pkt_ff.dst;
   assign rsp_bus.out_time    = rsp_pkt_ff.stamp;
   assign rsp_bus.match_count = rsp_count_ff;

endmodule

`default_nettype wire

[rtl/bpfd_checker.sv]
// ----------------------------------------------------------------------------
// bpfd_checker
// Port-level assertions for the bounded packet FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_success,
   input wire logic [bpfd_pkg::NODE_W-1:0]   rsp_out_src,
   input wire logic [bpfd_pkg::NODE_W-1:0]   rsp_out_dst,
   input wire logic [bpfd_pkg::STAMP_W-1:0]  rsp_out_time,
   input wire logic [bpfd_pkg::CNT_W-1:0]    rsp_match_count
);

   import bpfd_pkg::*;

   // a pending response word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count) &&
         $stable(rsp_success) && $stable(rsp_out_time))
      else $error("response word changed while stalled");

   // reset leaves no response pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a request word is worked on before the next one is taken
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // a count result never comes with a forwarded packet or a success flag
   a_count_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_match_count != '0) |->
         !rsp_success && (rsp_out_src == '0) && (rsp_out_dst == '0) &&
         (rsp_out_time == '0))
      else $error("count response mixed with packet fields");

endmodule

bind bounded_packet_fifo_with_dedup bpfd_checker u_bpfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_success     (rsp_bus.success),
   .rsp_out_src     (rsp_bus.out_src),
   .rsp_out_dst     (rsp_bus.out_dst),
   .rsp_out_time    (rsp_bus.out_time),
   .rsp_match_count (rsp_bus.match_count)
);

`default_nettype wire

[tb/tb_bounded_packet_fifo_with_dedup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_packet_fifo_with_dedup
// Self-checking bench for the bounded packet FIFO with duplicate filter.
// A clocked driver feeds request words from a backlog queue. A scoreboard
// copy of the packet buffer computes the reply for each accepted word. A
// clocked monitor compares every reply, field by field, with the oldest
// reply still owed. The run walks through several memory limits, the
// extremes among them, with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_bounded_packet_fifo_with_dedup;
   import bpfd_pkg::*;

   localparam int RING_DEPTH  = 64;
   localparam int WORDS_PHASE = 200;
   localparam int NUM_PHASES  = 8;
   localparam int CYCLE_LIMIT = 1_000_000;

   // opcode 3 has no meaning in the block; it must leave everything alone
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct {
      logic [OP_W-1:0]    opcode;
      logic [NODE_W-1:0]  src;
      logic [NODE_W-1:0]  dst;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] lo;
      logic [STAMP_W-1:0] hi;
      bit                 drain;   // hold this word until no reply is owed
   } req_word_type;

   typedef struct packed {
      logic               success;
      logic [NODE_W-1:0]  src;
      logic [NODE_W-1:0]  dst;
      logic [STAMP_W-1:0] stamp;
      logic [CNT_W-1:0]   count;
   } reply_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   bpfd_req_if req_bus ();
   bpfd_rsp_if rsp_bus ();

   bounded_packet_fifo_with_dedup #(
      .DEPTH (RING_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scoreboard copy of the packet buffer
   // ---------------------------------------------------------------------
   slot_type           ring [RING_DEPTH];
   int                 head;
   int                 fill;
   logic [LIMIT_W-1:0] limit_q;

   req_word_type req_backlog [$];
   reply_type    owed_replies [$];
   slot_type     recent_pkts [$];   // triples sent lately, reused to provoke duplicates
   req_word_type drv_word;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int replies_seen;
   int cycles;
   int n_stored, n_dup, n_evict, n_fwd, n_empty, n_count, n_spare;

   int phase_limits [NUM_PHASES] = '{127, 40, 1, 64, 0, 8, 96, 5};

   // Apply one accepted request word to the buffer copy and return the reply.
   function automatic reply_type apply_request(input req_word_type w);
      reply_type r;
      slot_type  pk;
      bit        dup;
      int        lim;
      int        hits;
      int        s;
      r  = '0;
      pk = {w.src, w.dst, w.stamp};
      case (w.opcode)
         OP_ADD: begin
            // scan every live packet, the oldest too, before any eviction
            dup = 1'b0;
            for (int i = 0; i < fill; i++)
               if (ring[(head + i) % RING_DEPTH] == pk) dup = 1'b1;
            if (dup) begin
               n_dup++;
            end else begin
               // zero acts as one, anything above the depth as the depth
               lim = (limit_q == 0) ? 1 : (limit_q > RING_DEPTH) ? RING_DEPTH : int'(limit_q);
               while (fill >= lim) begin
                  head = (head + 1) % RING_DEPTH;
                  fill--;
                  n_evict++;
               end
               ring[(head + fill) % RING_DEPTH] = pk;
               fill++;
               r.success = 1'b1;
               n_stored++;
            end
         end
         OP_FWD: begin
            if (fill != 0) begin
               pk        = ring[head];
               r.success = 1'b1;
               r.src     = pk.src;
               r.dst     = pk.dst;
               r.stamp   = pk.stamp;
               head      = (head + 1) % RING_DEPTH;
               fill--;
               n_fwd++;
            end else begin
               n_empty++;
            end
         end
         OP_COUNT: begin
            // an inverted range simply never matches
            hits = 0;
            for (int i = 0; i < fill; i++) begin
               s = (head + i) % RING_DEPTH;
               if (ring[s].dst == w.dst && ring[s].stamp >= w.lo && ring[s].stamp <= w.hi)
                  hits++;
            end
            r.count = hits[CNT_W-1:0];
            n_count++;
         end
         default: begin
            n_spare++;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: launch backlog words, hold each until the block takes it
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         // predict at acceptance, so config changes between phases line up
         if (req_bus.valid && req_bus.ready) begin
            owed_replies.insert(owed_replies.size(), apply_request(drv_word));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_backlog.size() != 0 &&
                !(req_backlog[0].drain && owed_replies.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               drv_word            = req_backlog.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.opcode      <= drv_word.opcode;
               req_bus.src_node    <= drv_word.src;
               req_bus.dst_node    <= drv_word.dst;
               req_bus.pkt_time    <= drv_word.stamp;
               req_bus.range_start <= drv_word.lo;
               req_bus.range_end   <= drv_word.hi;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each reply word with the oldest one owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.success, rsp_bus.out_src, rsp_bus.out_dst,
                   rsp_bus.out_time, rsp_bus.match_count};
            replies_seen++;
            if (owed_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] reply with none owed: ok=%0d src=%h dst=%h time=%h count=%0d",
                           $realtime, got.success, got.src, got.dst, got.stamp, got.count);
            end else begin
               want = owed_replies.pop_front();
               if (got.success !== want.success || got.src !== want.src ||
                   got.dst !== want.dst || got.stamp !== want.stamp ||
                   got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] reply mismatch: expected ok=%0d src=%h dst=%h time=%h count=%0d",
                              $realtime, want.success, want.src, want.dst, want.stamp, want.count);
                     $display("[%0t]                 actual   ok=%0d src=%h dst=%h time=%h count=%0d",
                              $realtime, got.success, got.src, got.dst, got.stamp, got.count);
                  end
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[%0t] timeout with %0d replies owed", $realtime, owed_replies.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_word(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] src,
                             input logic [NODE_W-1:0] dst, input logic [STAMP_W-1:0] stamp,
                             input logic [STAMP_W-1:0] lo, input logic [STAMP_W-1:0] hi,
                             input bit drain);
      req_word_type w;
      w = '{opcode: op, src: src, dst: dst, stamp: stamp, lo: lo, hi: hi, drain: drain};
      req_backlog.insert(req_backlog.size(), w);
   endtask

   // Build one random word. Adds draw mostly from small pools of nodes and
   // times so duplicates and count hits are common; the rest use full-width
   // values so every bit toggles.
   task automatic queue_random_word(input int add_pct, input int fwd_pct, input bit drain);
      logic [OP_W-1:0]    op;
      logic [NODE_W-1:0]  src;
      logic [NODE_W-1:0]  dst;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] lo;
      logic [STAMP_W-1:0] hi;
      slot_type           pk;
      int                 pick;
      int                 roll;
      src   = NODE_W'($urandom);
      dst   = NODE_W'($urandom);
      stamp = $urandom;
      lo    = $urandom;
      hi    = $urandom;
      pick  = $urandom_range(99);
      roll  = $urandom_range(99);
      if (pick < add_pct) begin
         op = OP_ADD;
         if (roll < 20 && recent_pkts.size() != 0) begin
            pk    = recent_pkts[$urandom_range(recent_pkts.size() - 1)];
            src   = pk.src;
            dst   = pk.dst;
            stamp = pk.stamp;
         end else if (roll < 85) begin
            src   = NODE_W'($urandom_range(3));
            dst   = NODE_W'($urandom_range(3));
            stamp = $urandom_range(15);
         end
         recent_pkts.insert(recent_pkts.size(), {src, dst, stamp});
         if (recent_pkts.size() > 80) void'(recent_pkts.pop_front());
      end else if (pick < add_pct + fwd_pct) begin
         op = OP_FWD;
      end else if (pick < 96) begin
         op = OP_COUNT;
         if ($urandom_range(99) < 80) dst = NODE_W'($urandom_range(3));
         if (roll < 70) begin
            // small bounds, inverted about half of the time
            lo = $urandom_range(16);
            hi = $urandom_range(16);
         end else if (roll < 85) begin
            lo = '0;
            hi = '1;
         end
      end else begin
         op = OP_SPARE;
      end
      queue_word(op, src, dst, stamp, lo, hi, drain);
   endtask

   // Wait until every word is taken and every reply has come back.
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_bus.valid || owed_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the memory limit; only called with the block idle.
   task automatic program_limit(input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_q = value;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      // drive every input to a known value from time zero
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_ADD;
      req_bus.src_node    = '0;
      req_bus.dst_node    = '0;
      req_bus.pkt_time    = '0;
      req_bus.range_start = '0;
      req_bus.range_end   = '0;
      rsp_bus.ready       = 1'b0;
      head                = 0;
      fill                = 0;
      limit_q             = LIMIT_RESET;
      mismatches          = 0;
      replies_seen        = 0;
      cycles              = 0;
      send_idle_pct       = 28;
      recv_idle_pct       = 58;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty buffer, unused opcode, field extremes, duplicate
      // rejection, inverted and single-point count ranges.
      queue_word(OP_FWD,   '1, '1, '1, '1, '1, 1'b0);       // forward on empty
      queue_word(OP_COUNT, '0, '0, '0, '0, '1, 1'b0);       // count on empty
      queue_word(OP_SPARE, '1, '1, '1, '1, '1, 1'b0);
      queue_word(OP_ADD,   '0, '0, '0, '0, '0, 1'b0);
      queue_word(OP_ADD,   '1, '1, '1, '1, '1, 1'b0);
      queue_word(OP_ADD,   '0, '0, '0, '1, '1, 1'b0);       // duplicate
      queue_word(OP_ADD,   '1, '1, 32'hFFFF_FFFE, '0, '0, 1'b0);
      queue_word(OP_ADD,   '0, '1, '0, '0, '0, 1'b0);
      queue_word(OP_COUNT, '0, '1, '0, '0, '1, 1'b0);
      queue_word(OP_COUNT, '0, '1, '0, '1, '1, 1'b0);
      queue_word(OP_COUNT, '0, '1, '0, 32'd5, 32'd4, 1'b0);  // inverted range
      queue_word(OP_COUNT, '1, '0, '1, '0, '0, 1'b0);
      queue_word(OP_SPARE, '0, '0, '0, '0, '0, 1'b0);
      queue_word(OP_FWD,   '0, '0, '0, '0, '0, 1'b0);
      queue_word(OP_FWD,   '0, '0, '0, '0, '0, 1'b0);
      wait_drained();

      // Limit of two: evict on the next add, then reject a copy of the oldest.
      program_limit(7'd2);
      queue_word(OP_ADD, 16'd1, 16'd2, 32'd3, '0, '0, 1'b0);
      queue_word(OP_ADD, '0, '1, '0, '0, '0, 1'b0);
      queue_word(OP_FWD, '0, '0, '0, '0, '0, 1'b0);
      wait_drained();

      // Limit of zero behaves as one.
      program_limit(7'd0);
      queue_word(OP_ADD, 16'd1, 16'd2, 32'd3, '0, '0, 1'b0);
      queue_word(OP_ADD, 16'd4, 16'd5, 32'd6, '0, '0, 1'b0);
      queue_word(OP_FWD, '0, '0, '0, '0, '0, 1'b0);
      queue_word(OP_FWD, '0, '0, '0, '0, '0, 1'b0);
      wait_drained();

      // Random phases. Large limits lean on adds so the buffer fills and
      // evicts; a lower limit after a full buffer trims several packets at
      // once. One word per phase holds off until all replies are back.
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 58;
         end else if (p < 6) begin
            send_idle_pct = 58;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_limit(phase_limits[p][LIMIT_W-1:0]);
         for (int n = 0; n < WORDS_PHASE; n++) begin
            if (phase_limits[p] >= 40) queue_random_word(55, 15, n == WORDS_PHASE / 2);
            else                       queue_random_word(40, 25, n == WORDS_PHASE / 2);
         end
         wait_drained();
      end

      // let any stray reply surface before the verdict
      repeat (70) @(posedge clock);

      $display("Covered %0d replies: %0d packets stored, %0d duplicates, %0d evictions",
               replies_seen, n_stored, n_dup, n_evict);
      $display("  %0d forwards, %0d empty forwards, %0d counts, %0d spare opcodes, %0d mismatches",
               n_fwd, n_empty, n_count, n_spare, mismatches);
      if (mismatches == 0 && owed_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
rtl/bpfd_pkg.sv
rtl/bpfd_if.sv
rtl/bpfd_ram.sv
rtl/bounded_packet_fifo_with_dedup.sv
rtl/bpfd_checker.sv
tb/tb_bounded_packet_fifo_with_dedup.sv
